// File: rtl/llsc_mem_pkg.sv
package llsc_mem_pkg;

   localparam int ADDR_W  = 12;
   localparam int WADDR_W = ADDR_W - 2;   // word address bits of a byte address
   localparam int THR_W   = 4;
   localparam int DATA_W  = 32;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LL    = 2'd2,
      CMD_SC    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_PLAIN = 2'd0,
      ST_LL    = 2'd1,
      ST_ACK   = 2'd2,
      ST_NACK  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [THR_W-1:0]    thread;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   wdata;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   rdata;
      status_type          status;
   } rsp_type;

endpackage

// File: rtl/ll_sc_reservation_memory.sv
// Word memory with a per-thread load-linked / store-conditional reservation table.
// Request channel (req_valid/req_ready/req_data): one word carries cmd, thread, byte
// address and write data. Response channel (rsp_valid/rsp_ready/rsp_data): exactly
// one word per request, in request order: read data, echoed write data, or the
// store-conditional outcome (1/0) with a status code.
// Timing: a request is taken in IDLE, memory and reservation-address RAMs are read
// as it is taken (registered read), and in the lookup cycle the response is loaded
// into the output register if the output slot is free, else it is held in a holding
// register and loaded from state RESP. A successful store-conditional instead
// sweeps the reservation table through the single reservation-address read port and
// one shared word-address comparator, one thread per cycle, reading one entry while
// comparing the one before it and clearing other threads' reservations on the same
// word; the response then goes out from RESP.
// req_ready is high only in IDLE; one request is in flight at a time.
// If the receiver stalls, the response waits in the output register (or a holding
// register behind it); the block keeps req_ready low until it can hand it over.
// Reset clears the state machine, the output valid and all reservation valid bits.
// Memory words and reservation addresses are not cleared; memory words must be
// written before they are read.
module ll_sc_reservation_memory #(
   parameter int THREADS   = 16,
   parameter int MEM_WORDS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  llsc_mem_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output llsc_mem_pkg::rsp_type rsp_data
);

   localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;   // reservation index
   localparam int TCW = $clog2(THREADS + 1);                   // sweep counter
   localparam int MW  = $clog2(MEM_WORDS);                     // memory index

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_SWEEP,
      S_RESP
   } state_type;

   // word index = (addr >> 2) mod MEM_WORDS, by conditional subtraction
   function automatic logic [MW-1:0] word_index(input logic [llsc_mem_pkg::ADDR_W-1:0] a);
      logic [llsc_mem_pkg::WADDR_W-1:0] v;
      v = a[llsc_mem_pkg::ADDR_W-1:2];
      for (int k = 6; k >= 0; k--) begin
         if (32'(v) >= (MEM_WORDS << k)) begin
            v = v - llsc_mem_pkg::WADDR_W'(MEM_WORDS << k);
         end
      end
      return MW'(v);
   endfunction

   // storage
   logic [llsc_mem_pkg::DATA_W-1:0] mem_words [MEM_WORDS];
   logic [llsc_mem_pkg::ADDR_W-1:0] resv_addr [THREADS];

   // registers
   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   llsc_mem_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   llsc_mem_pkg::rsp_type           res_ff, res_in;
   llsc_mem_pkg::req_type           req_ff, req_in;
   logic [MW-1:0]                   idx_ff, idx_in;
   logic [THREADS-1:0]              resv_valid_ff, resv_valid_in;
   logic [TCW-1:0]                  swp_ff, swp_in;
   logic                            pend_ff, pend_in;
   logic [TW-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic [llsc_mem_pkg::DATA_W-1:0] mem_rd_ff;
   logic [llsc_mem_pkg::ADDR_W-1:0] resv_rd_ff;

   // combinational
   logic                            accept;
   logic                            thr_ok;
   logic [TW-1:0]                   tidx;
   logic                            sc_hit;
   logic                            slot_free;
   llsc_mem_pkg::rsp_type           lookup_res;
   logic                            resv_rd_en;
   logic [TW-1:0]                   resv_rd_addr;
   logic                            mem_wr_en;
   logic                            resv_wr_en;
   logic                            word_match;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // thread check on the latched request
   assign thr_ok = (32'(req_ff.thread) < THREADS);
   assign tidx   = TW'(req_ff.thread);

   assign sc_hit = thr_ok && resv_valid_ff[tidx] && (resv_rd_ff == req_ff.addr);

   // shared comparator: word address of the swept entry vs. the request
   assign word_match = (resv_rd_ff[llsc_mem_pkg::ADDR_W-1:2] ==
                        req_ff.addr[llsc_mem_pkg::ADDR_W-1:2]);

   always_comb begin
      lookup_res = '{rdata: mem_rd_ff, status: llsc_mem_pkg::ST_PLAIN};
      case (req_ff.cmd)
         llsc_mem_pkg::CMD_READ: begin
            lookup_res = '{rdata: mem_rd_ff, status: llsc_mem_pkg::ST_PLAIN};
         end
         llsc_mem_pkg::CMD_WRITE: begin
            lookup_res = '{rdata: req_ff.wdata, status: llsc_mem_pkg::ST_PLAIN};
         end
         llsc_mem_pkg::CMD_LL: begin
            lookup_res = '{rdata: mem_rd_ff, status: llsc_mem_pkg::ST_LL};
         end
         llsc_mem_pkg::CMD_SC: begin
            if (sc_hit) begin
               lookup_res = '{rdata: llsc_mem_pkg::DATA_W'(1), status: llsc_mem_pkg::ST_ACK};
            end else begin
               lookup_res = '{rdata: '0, status: llsc_mem_pkg::ST_NACK};
            end
         end
         default: begin
            lookup_res = '{rdata: mem_rd_ff, status: llsc_mem_pkg::ST_PLAIN};
         end
      endcase
   end

   // RAM port controls
   always_comb begin
      resv_rd_en   = 1'b0;
      resv_rd_addr = TW'(req_data.thread);
      if (accept) begin
         resv_rd_en   = 1'b1;
         resv_rd_addr = TW'(req_data.thread);
      end else if (state_ff == S_SWEEP && swp_ff < TCW'(THREADS)) begin
         resv_rd_en   = 1'b1;
         resv_rd_addr = swp_ff[TW-1:0];
      end
   end

   assign mem_wr_en  = (state_ff == S_LOOKUP) &&
                       ((req_ff.cmd == llsc_mem_pkg::CMD_WRITE) ||
                        ((req_ff.cmd == llsc_mem_pkg::CMD_SC) && sc_hit));
   assign resv_wr_en = (state_ff == S_LOOKUP) && (req_ff.cmd == llsc_mem_pkg::CMD_LL) &&
                       thr_ok;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      res_in        = res_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      resv_valid_in = resv_valid_ff;
      swp_in        = swp_ff;
      pend_in       = 1'b0;
      cmp_idx_in    = cmp_idx_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               idx_in   = word_index(req_data.addr);
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            res_in = lookup_res;
            if (resv_wr_en) begin
               resv_valid_in[tidx] = 1'b1;
            end
            if (req_ff.cmd == llsc_mem_pkg::CMD_SC && sc_hit) begin
               swp_in   = '0;
               state_in = S_SWEEP;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = lookup_res;
               state_in     = S_IDLE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SWEEP: begin
            // read entry swp_ff while comparing the entry read last cycle
            if (swp_ff < TCW'(THREADS)) begin
               pend_in    = 1'b1;
               cmp_idx_in = swp_ff[TW-1:0];
               swp_in     = swp_ff + TCW'(1);
            end
            if (pend_ff && word_match && cmp_idx_ff != tidx) begin
               resv_valid_in[cmp_idx_ff] = 1'b0;
            end
            if (swp_ff == TCW'(THREADS) && !pend_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         resv_valid_ff <= '0;
         pend_ff       <= 1'b0;
         swp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         resv_valid_ff <= resv_valid_in;
         pend_ff       <= pend_in;
         swp_ff        <= swp_in;
      end
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
   end

   // data memory: read on accept, write in lookup
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= mem_words[word_index(req_data.addr)];
      end
      if (mem_wr_en) begin
         mem_words[idx_ff] <= req_ff.wdata;
      end
   end

   // reservation address memory
   always_ff @(posedge clock) begin
      if (resv_rd_en) begin
         resv_rd_ff <= resv_addr[resv_rd_addr];
      end
      if (resv_wr_en) begin
         resv_addr[tidx] <= req_ff.addr;
      end
   end

endmodule
